### rtl/linear_interpolation_resampler_macros.svh
// ----------------------------------------------------------------------------
// Linear interpolation resampler assertion macros
// Shared macros for the concurrent checks on the resampler ports.
// ----------------------------------------------------------------------------
`ifndef LINEAR_INTERPOLATION_RESAMPLER_MACROS_SVH
`define LINEAR_INTERPOLATION_RESAMPLER_MACROS_SVH

// Check that holds only while the block is out of reset.
`define LIR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that is also evaluated across reset.
`define LIR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/lir_pkg.sv
// ----------------------------------------------------------------------------
// Linear interpolation resampler package
// Types and constants shared by the sequencer and the arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lir_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_STEP  = 2'd2;

  // Step counts of the shared unit.
  localparam logic [5:0] QUOT_STEPS = 6'd32;  // grid count division
  localparam logic [5:0] MUL_STEPS  = 6'd32;  // 32 x 32 shift-add multiply
  localparam logic [5:0] FRAC_STEPS = 6'd40;  // quotient bits below the cap

  typedef enum logic [1:0] {
    OP_MUL = 2'b01,
    OP_DIV = 2'b10
  } arith_op_t;

  // Request to the shared multiply / divide unit.
  typedef struct packed {
    logic        start;
    arith_op_t   op;
    logic [5:0]  steps;
    logic [32:0] hi;
    logic [39:0] lo;
    logic [31:0] opnd;
  } arith_req_t;

  // Result of the shared unit, valid while done is high.
  typedef struct packed {
    logic        done;
    logic [32:0] hi;
    logic [39:0] lo;
  } arith_rsp_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_QDIV   = 6'b000010,
    S_LAUNCH = 6'b000100,
    S_MUL    = 6'b001000,
    S_DIV    = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

endpackage

### rtl/lir_arith.sv
// ----------------------------------------------------------------------------
// Shared multiply / divide unit
// Bit-serial shift-add multiplier and restoring divider on one register pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lir_arith (
  input  logic                clk,
  input  logic                rst_n,
  input  lir_pkg::arith_req_t req,
  output lir_pkg::arith_rsp_t rsp
);
  import lir_pkg::*;

  logic        busy_r;
  logic        done_r;
  arith_op_t   op_r;
  logic [5:0]  cnt_r;
  logic [32:0] hi_r;
  logic [39:0] lo_r;
  logic [31:0] opnd_r;

  logic [32:0] hi_nxt;
  logic [39:0] lo_nxt;
  logic [32:0] mul_sum;
  logic [32:0] div_rs;
  logic        div_ge;

  // One multiply step adds the operand when the low bit is set and shifts
  // right; one divide step shifts in a dividend bit and subtracts when it fits.
  always_comb begin
    mul_sum = hi_r + {1'b0, (lo_r[0] ? opnd_r : 32'd0)};
    div_rs  = {hi_r[31:0], lo_r[39]};
    div_ge  = div_rs >= {1'b0, opnd_r};
    case (op_r)
      OP_MUL: begin
        hi_nxt = {1'b0, mul_sum[32:1]};
        lo_nxt = {lo_r[39:32], mul_sum[0], lo_r[31:1]};
      end
      OP_DIV: begin
        hi_nxt = div_ge ? (div_rs - {1'b0, opnd_r}) : div_rs;
        lo_nxt = {lo_r[38:0], div_ge};
      end
      default: begin
        hi_nxt = hi_r;
        lo_nxt = lo_r;
      end
    endcase
  end

  // Control: busy flag, step counter and the done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= OP_MUL;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
        op_r   <= req.op;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      hi_r   <= req.hi;
      lo_r   <= req.lo;
      opnd_r <= req.opnd;
    end else if (busy_r) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.hi   = hi_r;
  assign rsp.lo   = lo_r;

endmodule

### rtl/linear_interpolation_resampler.sv
// ----------------------------------------------------------------------------
// Linear interpolation resampler
// Resamples one complex sample stream onto a uniform time grid.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the in_ stream (time, real, imaginary; tlast marks the
//   final sample). Results leave on the out_ stream (grid time, real,
//   imaginary; tlast on the last result of a sample, tuser = zero interval and
//   dropped points flags). Grid registers are written on the cfg_ port.
//   The first sample of a stream only primes the block, and a sample whose
//   interval holds no grid point is taken without a result. Any other sample
//   counts its grid points with a 32-step division, then builds each result
//   on the shared unit: per component one 32-step multiply and one 40-step
//   divide, up to MAX_RUN results per sample. A component of a zero-length
//   interval or with a capped quotient skips its divide.
//   in_tready is high only while no sample is being worked on; the next sample
//   may enter while the last result still waits in the output register. A
//   stalled receiver holds the sequencer before loading the next result.
//   Reset clears all stream state and loads the default grid registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_interpolation_resampler #(
  parameter int unsigned MAX_RUN = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: sample_time[31:0], value_re[63:32], value_im[95:64]
  input  logic [95:0]                    in_tdata,
  input  logic                           in_tlast,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // out_tdata: grid_time[31:0], out_re[63:32], out_im[95:64]
  output logic [95:0]                    out_tdata,
  output logic                           out_tlast,
  // out_tuser: zero_interval[0], points_dropped[1]
  output logic [1:0]                     out_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_we,
  input  logic [lir_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [31:0]                    cfg_wdata
);
  import lir_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_RUN + 1);

  // Configuration registers.
  logic signed [31:0] grid_start_r, grid_end_r;
  logic [30:0]        grid_step_r;

  // Stream state.
  logic signed [31:0] prev_time_r, prev_re_r, prev_im_r;
  logic               have_prev_r;
  logic signed [32:0] next_r;
  logic               grid_done_r;

  // Current sample and run state.
  logic signed [31:0] cur_time_r, cur_re_r, cur_im_r;
  logic               fin_r;
  logic signed [32:0] lim_r, next_after_r, t_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               dropped_r;
  logic               comp_r;
  logic signed [31:0] res_re_r, res_im_r;
  state_t             state_r;

  // Output register.
  logic               out_valid_r;
  logic [95:0]        out_data_r;
  logic               out_last_r;
  logic [1:0]         out_user_r;

  // Next values.
  logic signed [31:0] prev_time_nxt, prev_re_nxt, prev_im_nxt;
  logic               have_prev_nxt;
  logic signed [32:0] next_nxt;
  logic               grid_done_nxt;
  logic signed [32:0] lim_nxt, next_after_nxt, t_nxt;
  logic [CNT_W-1:0]   cnt_nxt;
  logic               dropped_nxt, comp_nxt;
  logic signed [31:0] res_re_nxt, res_im_nxt;
  state_t             state_nxt;
  logic               out_valid_nxt, out_load;

  arith_req_t         req;
  arith_rsp_t         rsp;

  lir_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Input fields and grid limits.
  logic signed [31:0] in_time, in_re, in_im;
  logic               in_fire;
  logic [30:0]        step_eff;
  logic signed [32:0] ge33, ge_m1, tc33, lim, d33;
  logic               run_ok;

  always_comb begin
    in_time  = $signed(in_tdata[31:0]);
    in_re    = $signed(in_tdata[63:32]);
    in_im    = $signed(in_tdata[95:64]);
    in_fire  = in_tvalid && in_tready;
    step_eff = (grid_step_r == 31'd0) ? 31'd1 : grid_step_r;
    ge33     = {grid_end_r[31], grid_end_r};
    ge_m1    = ge33 - 33'sd1;
    tc33     = {in_time[31], in_time};
    lim      = (!in_tlast && (tc33 < ge_m1)) ? tc33 : ge_m1;
    run_ok   = !grid_done_r && (next_r <= lim);
    d33      = lim - next_r;
  end

  // Interpolation operands for the component in work.
  logic signed [33:0] dt;
  logic signed [32:0] diff, den;
  logic signed [31:0] p_sel, c_sel;
  logic [31:0]        dt_mag, diff_mag, den_mag;
  logic               neg, den_zero, frac_sat;
  logic [63:0]        prod;
  logic [40:0]        q_use;
  logic signed [41:0] sum42;
  logic signed [31:0] comp_res;

  always_comb begin
    p_sel    = comp_r ? prev_im_r : prev_re_r;
    c_sel    = comp_r ? cur_im_r : cur_re_r;
    dt       = {t_r[32], t_r} - {{2{prev_time_r[31]}}, prev_time_r};
    diff     = {c_sel[31], c_sel} - {p_sel[31], p_sel};
    den      = {cur_time_r[31], cur_time_r} - {prev_time_r[31], prev_time_r};
    dt_mag   = dt[33] ? 32'(-dt) : dt[31:0];
    diff_mag = diff[32] ? 32'(-diff) : diff[31:0];
    den_mag  = den[32] ? 32'(-den) : den[31:0];
    den_zero = (den == 33'sd0);
    neg      = dt[33] ^ diff[32] ^ den[32];
    prod     = {rsp.hi[31:0], rsp.lo[31:0]};
    // Quotient reaches the cap when the bits above the fraction field divide.
    frac_sat = {8'd0, prod[63:40]} >= den_mag;
    if (state_r == S_DIV) begin
      q_use = {1'b0, rsp.lo[39:0]};
    end else if (den_zero) begin
      q_use = '0;
    end else begin
      q_use = {1'b1, 40'd0};
    end
    sum42 = neg ? ({{10{p_sel[31]}}, p_sel} - $signed({1'b0, q_use}))
                : ({{10{p_sel[31]}}, p_sel} + $signed({1'b0, q_use}));
    if (sum42 > 42'sd2147483647) begin
      comp_res = 32'sh7FFFFFFF;
    end else if (sum42 < -42'sd2147483648) begin
      comp_res = 32'sh80000000;
    end else begin
      comp_res = sum42[31:0];
    end
  end

  // Sequencer.
  always_comb begin
    prev_time_nxt  = prev_time_r;
    prev_re_nxt    = prev_re_r;
    prev_im_nxt    = prev_im_r;
    have_prev_nxt  = have_prev_r;
    next_nxt       = next_r;
    grid_done_nxt  = grid_done_r;
    lim_nxt        = lim_r;
    next_after_nxt = next_after_r;
    t_nxt          = t_r;
    cnt_nxt        = cnt_r;
    dropped_nxt    = dropped_r;
    comp_nxt       = comp_r;
    res_re_nxt     = res_re_r;
    res_im_nxt     = res_im_r;
    state_nxt      = state_r;
    out_load       = 1'b0;
    req.start      = 1'b0;
    req.op         = OP_MUL;
    req.steps      = MUL_STEPS;
    req.hi         = '0;
    req.lo         = {8'd0, dt_mag};
    req.opnd       = diff_mag;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (!have_prev_r) begin
            if (!in_tlast) begin
              // Priming sample.
              prev_time_nxt = in_time;
              prev_re_nxt   = in_re;
              prev_im_nxt   = in_im;
              have_prev_nxt = 1'b1;
              next_nxt      = {grid_start_r[31], grid_start_r};
              grid_done_nxt = grid_start_r >= grid_end_r;
            end else begin
              have_prev_nxt = 1'b0;
            end
          end else if (run_ok) begin
            // Count grid points up to the limit.
            lim_nxt   = lim;
            req.start = 1'b1;
            req.op    = OP_DIV;
            req.steps = QUOT_STEPS;
            req.hi    = '0;
            req.lo    = {d33[31:0], 8'd0};
            req.opnd  = {1'b0, step_eff};
            state_nxt = S_QDIV;
          end else begin
            // No grid point in this interval.
            grid_done_nxt = grid_done_r || (next_r >= ge33);
            prev_time_nxt = in_time;
            prev_re_nxt   = in_re;
            prev_im_nxt   = in_im;
          end
          if (have_prev_r && in_tlast && !run_ok) begin
            prev_time_nxt = '0;
            prev_re_nxt   = '0;
            prev_im_nxt   = '0;
            have_prev_nxt = 1'b0;
            next_nxt      = '0;
            grid_done_nxt = 1'b0;
          end
          if (!have_prev_r && in_tlast) begin
            prev_time_nxt = '0;
            prev_re_nxt   = '0;
            prev_im_nxt   = '0;
            next_nxt      = '0;
            grid_done_nxt = 1'b0;
          end
        end
      end

      S_QDIV: begin
        if (rsp.done) begin
          dropped_nxt    = rsp.lo[31:0] >= 32'(MAX_RUN);
          cnt_nxt        = (rsp.lo[31:0] >= 32'(MAX_RUN)) ? CNT_W'(MAX_RUN)
                                                          : CNT_W'(rsp.lo[31:0] + 32'd1);
          next_after_nxt = lim_r - $signed({1'b0, rsp.hi[31:0]})
                           + $signed({2'b0, step_eff});
          t_nxt          = next_r;
          comp_nxt       = 1'b0;
          state_nxt      = S_LAUNCH;
        end
      end

      S_LAUNCH: begin
        req.start = 1'b1;
        state_nxt = S_MUL;
      end

      S_MUL: begin
        if (rsp.done) begin
          if (den_zero || frac_sat) begin
            if (!comp_r) begin
              res_re_nxt = comp_res;
              comp_nxt   = 1'b1;
              state_nxt  = S_LAUNCH;
            end else begin
              res_im_nxt = comp_res;
              state_nxt  = S_EMIT;
            end
          end else begin
            req.start = 1'b1;
            req.op    = OP_DIV;
            req.steps = FRAC_STEPS;
            req.hi    = {9'd0, prod[63:40]};
            req.lo    = prod[39:0];
            req.opnd  = den_mag;
            state_nxt = S_DIV;
          end
        end
      end

      S_DIV: begin
        if (rsp.done) begin
          if (!comp_r) begin
            res_re_nxt = comp_res;
            comp_nxt   = 1'b1;
            state_nxt  = S_LAUNCH;
          end else begin
            res_im_nxt = comp_res;
            state_nxt  = S_EMIT;
          end
        end
      end

      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_load = 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
            if (fin_r) begin
              prev_time_nxt = '0;
              prev_re_nxt   = '0;
              prev_im_nxt   = '0;
              have_prev_nxt = 1'b0;
              next_nxt      = '0;
              grid_done_nxt = 1'b0;
            end else begin
              next_nxt      = next_after_r;
              grid_done_nxt = grid_done_r || (next_after_r >= ge33);
              prev_time_nxt = cur_time_r;
              prev_re_nxt   = cur_re_r;
              prev_im_nxt   = cur_im_r;
            end
          end else begin
            cnt_nxt   = cnt_r - CNT_W'(1);
            t_nxt     = t_r + $signed({2'b0, step_eff});
            comp_nxt  = 1'b0;
            state_nxt = S_LAUNCH;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_tready);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_start_r <= '0;
      grid_end_r   <= '0;
      grid_step_r  <= 31'd1;
      prev_time_r  <= '0;
      prev_re_r    <= '0;
      prev_im_r    <= '0;
      have_prev_r  <= 1'b0;
      next_r       <= '0;
      grid_done_r  <= 1'b0;
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_GRID_START: grid_start_r <= $signed(cfg_wdata);
          REG_GRID_END:   grid_end_r   <= $signed(cfg_wdata);
          REG_GRID_STEP:  grid_step_r  <= cfg_wdata[30:0];
          default:        grid_step_r  <= grid_step_r;
        endcase
      end
      prev_time_r <= prev_time_nxt;
      prev_re_r   <= prev_re_nxt;
      prev_im_r   <= prev_im_nxt;
      have_prev_r <= have_prev_nxt;
      next_r      <= next_nxt;
      grid_done_r <= grid_done_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_time_r <= in_time;
      cur_re_r   <= in_re;
      cur_im_r   <= in_im;
      fin_r      <= in_tlast;
    end
    lim_r        <= lim_nxt;
    next_after_r <= next_after_nxt;
    t_r          <= t_nxt;
    cnt_r        <= cnt_nxt;
    dropped_r    <= dropped_nxt;
    comp_r       <= comp_nxt;
    res_re_r     <= res_re_nxt;
    res_im_r     <= res_im_nxt;
    if (out_load) begin
      out_data_r <= {res_im_r, res_re_r, t_r[31:0]};
      out_last_r <= (cnt_r == CNT_W'(1));
      out_user_r <= {dropped_r, den_zero};
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule

### rtl/lir_checker.sv
// ----------------------------------------------------------------------------
// Linear interpolation resampler port checker
// Watches the top-level ports over time and is bound to every instance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "linear_interpolation_resampler_macros.svh"

module lir_checker (
  input logic        clk,
  input logic        rst_n,
  input logic [95:0] in_tdata,
  input logic        in_tlast,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [95:0] out_tdata,
  input logic        out_tlast,
  input logic [1:0]  out_tuser,
  input logic        out_tvalid,
  input logic        out_tready
);

  // No result is offered right after reset.
  `LIR_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_tvalid, "result valid after reset")

  // A stalled result request keeps its payload.
  `LIR_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled result changed")

  // A waiting sample request keeps its payload.
  `LIR_ASSERT(a_in_hold, clk, rst_n, in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tlast), "waiting sample changed")

  // While a run is not finished the block takes no new sample.
  `LIR_ASSERT(a_run_busy, clk, rst_n, out_tvalid && !out_tlast |-> !in_tready, "sample accepted inside a run")

endmodule

bind linear_interpolation_resampler lir_checker u_lir_checker (.*);
